FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the engine RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the command front end, queue and engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam int HP_WIDTH       = 16;
    localparam int WAIT_CNT_WIDTH = HP_WIDTH + 1;
    localparam int RECOVERY_STOPS = 8;
    localparam int BITS_PER_BYTE  = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_XFER  = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_CHK   = 5'd1,
        PH_ST_SCLH  = 5'd2,
        PH_ST_SDAL  = 5'd3,
        PH_ST_SCLL  = 5'd4,
        PH_TX_SETUP = 5'd5,
        PH_TX_HIGH  = 5'd6,
        PH_TX_LOW   = 5'd7,
        PH_AK_REL   = 5'd8,
        PH_AK_SCLH  = 5'd9,
        PH_AK_SAMP  = 5'd10,
        PH_AK_LOW   = 5'd11,
        PH_RX_LOW   = 5'd12,
        PH_RX_HIGH  = 5'd13,
        PH_RX_TAIL  = 5'd14,
        PH_RK_SET   = 5'd15,
        PH_RK_HIGH  = 5'd16,
        PH_RK_TAIL  = 5'd17,
        PH_SP_SCLL  = 5'd18,
        PH_SP_SDAL  = 5'd19,
        PH_SP_SCLH  = 5'd20,
        PH_SP_FREE  = 5'd21
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       last;
        logic       sda;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master command front end
// Accepts stream items, decodes the request kind and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        queue_full,
    output logic             push,
    output item_t            push_item
);

    cmd_t cmd;

    assign cmd            = cmd_t'(s_axis_tuser);
    assign s_axis_tready  = !queue_full;
    assign push           = s_axis_tvalid && !queue_full;
    assign push_item.cmd  = cmd;
    assign push_item.data = s_axis_tdata[7:0];
    assign push_item.last = s_axis_tlast;
    assign push_item.sda  = s_axis_tdata[8];

endmodule

`default_nettype wire

FILE: rtl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// I2C master command queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_queue
    import i2cm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output logic       full,
    output logic       not_empty,
    output item_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Runs one tick per queued item, sequences SCL and SDA and registers results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cm_engine
    import i2cm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [HP_WIDTH-1:0] half_period,
    input  wire logic                not_empty,
    input  wire item_t               head,
    output logic                     pop,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [15:0]              m_axis_tdata,
    output logic                     m_axis_tuser
);

    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic [WAIT_CNT_WIDTH-1:0] wait_reg;
    logic [WAIT_CNT_WIDTH-1:0] wait_next;
    logic [3:0]                bit_count_reg;
    logic [3:0]                bit_count_next;
    logic [7:0]                shift_reg;
    logic [7:0]                shift_next;
    logic                      nack_reg;
    logic                      nack_next;
    logic                      read_mode_reg;
    logic                      read_mode_next;
    logic [3:0]                recovery_reg;
    logic [3:0]                recovery_next;
    logic                      stop_pend_reg;
    logic                      stop_pend_next;
    logic                      scl_reg;
    logic                      scl_next;
    logic                      sda_reg;
    logic                      sda_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [15:0]               out_data_reg;
    logic                      out_user_reg;

    logic [HP_WIDTH-1:0]       hp_eff;
    logic [WAIT_CNT_WIDTH-1:0] unit1;
    logic [WAIT_CNT_WIDTH-1:0] unit2;
    logic [3:0]                bc_inc;
    logic [3:0]                rc_dec;
    logic                      rd_valid;
    logic                      rejected;
    logic [15:0]               res_data;

    assign hp_eff = (half_period == '0) ? HP_WIDTH'(1) : half_period;
    assign unit1  = {1'b0, hp_eff};
    assign unit2  = {hp_eff, 1'b0};
    assign bc_inc = bit_count_reg + 4'd1;
    assign rc_dec = recovery_reg - 4'd1;
    assign pop    = not_empty && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        nack_next      = nack_reg;
        read_mode_next = read_mode_reg;
        recovery_next  = recovery_reg;
        stop_pend_next = stop_pend_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rd_valid       = 1'b0;
        rejected       = 1'b0;
        if (pop)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rejected = (head.cmd != CMD_TICK);
                if (wait_reg > WAIT_CNT_WIDTH'(1))
                begin
                    wait_next = wait_reg - 1'b1;
                end
                else
                begin
                    wait_next = '0;
                    unique case (phase_reg) inside
                        PH_ST_CHK:
                        begin
                            if (!head.sda)
                            begin
                                recovery_next = 4'(RECOVERY_STOPS);
                                scl_next      = 1'b0;
                                phase_next    = PH_SP_SCLL;
                                wait_next     = unit1;
                            end
                            else
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_ST_SCLH;
                                wait_next  = unit1;
                            end
                        end
                        PH_ST_SCLH:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_ST_SDAL;
                            wait_next  = unit1;
                        end
                        PH_ST_SDAL:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_ST_SCLL;
                            wait_next  = unit1;
                        end
                        PH_ST_SCLL:
                        begin
                            bit_count_next = '0;
                            sda_next       = shift_reg[7];
                            phase_next     = PH_TX_SETUP;
                            wait_next      = unit1;
                        end
                        PH_TX_SETUP:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_TX_HIGH;
                            wait_next  = unit1;
                        end
                        PH_TX_HIGH:
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            scl_next   = 1'b0;
                            phase_next = PH_TX_LOW;
                            wait_next  = unit1;
                        end
                        PH_TX_LOW:
                        begin
                            bit_count_next = bc_inc;
                            if (bc_inc < 4'(BITS_PER_BYTE))
                            begin
                                sda_next   = shift_reg[7];
                                phase_next = PH_TX_SETUP;
                            end
                            else
                            begin
                                sda_next   = 1'b1;
                                phase_next = PH_AK_REL;
                            end
                            wait_next = unit1;
                        end
                        PH_AK_REL:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_AK_SCLH;
                            wait_next  = unit1;
                        end
                        PH_AK_SCLH:
                        begin
                            phase_next = PH_AK_SAMP;
                            wait_next  = unit2;
                        end
                        PH_AK_SAMP:
                        begin
                            nack_next  = nack_reg | head.sda;
                            scl_next   = 1'b0;
                            phase_next = PH_AK_LOW;
                            wait_next  = unit1;
                        end
                        PH_AK_LOW, PH_RK_TAIL:
                        begin
                            rd_valid = (phase_reg == PH_RK_TAIL);
                            if (stop_pend_reg)
                            begin
                                stop_pend_next = 1'b0;
                                scl_next       = 1'b0;
                                phase_next     = PH_SP_SCLL;
                                wait_next      = unit1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_RX_LOW:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_RX_HIGH;
                            wait_next  = unit2;
                        end
                        PH_RX_HIGH:
                        begin
                            shift_next = {shift_reg[6:0], head.sda};
                            scl_next   = 1'b0;
                            phase_next = PH_RX_TAIL;
                            wait_next  = unit1;
                        end
                        PH_RX_TAIL:
                        begin
                            bit_count_next = bc_inc;
                            if (bc_inc < 4'(BITS_PER_BYTE))
                            begin
                                phase_next = PH_RX_LOW;
                            end
                            else
                            begin
                                sda_next   = stop_pend_reg;
                                phase_next = PH_RK_SET;
                            end
                            wait_next = unit1;
                        end
                        PH_RK_SET:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_RK_HIGH;
                            wait_next  = unit1;
                        end
                        PH_RK_HIGH:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_RK_TAIL;
                            wait_next  = unit1;
                        end
                        PH_SP_SCLL:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_SP_SDAL;
                            wait_next  = unit1;
                        end
                        PH_SP_SDAL:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_SP_SCLH;
                            wait_next  = unit1;
                        end
                        PH_SP_SCLH:
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_SP_FREE;
                            wait_next  = unit1;
                        end
                        PH_SP_FREE:
                        begin
                            if (recovery_reg != '0)
                            begin
                                recovery_next = rc_dec;
                                if (rc_dec != '0)
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_SP_SCLL;
                                end
                                else
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_ST_SCLH;
                                end
                                wait_next = unit1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            else
            begin
                case (head.cmd)
                    CMD_START:
                    begin
                        nack_next      = 1'b0;
                        stop_pend_next = 1'b0;
                        recovery_next  = '0;
                        read_mode_next = head.data[0];
                        shift_next     = head.data;
                        sda_next       = 1'b1;
                        phase_next     = PH_ST_CHK;
                        wait_next      = unit1;
                    end
                    CMD_XFER:
                    begin
                        if (read_mode_reg)
                        begin
                            stop_pend_next = head.last | nack_reg;
                            shift_next     = '0;
                            bit_count_next = '0;
                            sda_next       = 1'b1;
                            phase_next     = PH_RX_LOW;
                            wait_next      = unit1;
                        end
                        else if (nack_reg)
                        begin
                            if (head.last)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_SP_SCLL;
                                wait_next  = unit1;
                            end
                        end
                        else
                        begin
                            stop_pend_next = head.last;
                            shift_next     = head.data;
                            bit_count_next = '0;
                            sda_next       = head.data[7];
                            phase_next     = PH_TX_SETUP;
                            wait_next      = unit1;
                        end
                    end
                    CMD_STOP:
                    begin
                        stop_pend_next = 1'b0;
                        recovery_next  = '0;
                        scl_next       = 1'b0;
                        phase_next     = PH_SP_SCLL;
                        wait_next      = unit1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_data        = '0;
        res_data[0]     = scl_next;
        res_data[1]     = sda_next;
        res_data[2]     = (phase_next == PH_IDLE);
        res_data[3]     = nack_next;
        res_data[11:4]  = rd_valid ? shift_next : 8'd0;
        res_data[12]    = rejected;
        out_valid_next  = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            nack_reg      <= 1'b0;
            read_mode_reg <= 1'b0;
            recovery_reg  <= '0;
            stop_pend_reg <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            nack_reg      <= nack_next;
            read_mode_reg <= read_mode_next;
            recovery_reg  <= recovery_next;
            stop_pend_reg <= stop_pend_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= res_data;
            out_user_reg <= rd_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `ASSERT_IMPLY(a_busy_has_wait, clk, rst_n, phase_reg != PH_IDLE, wait_reg != '0)
    `ASSERT_IMPLY(a_idle_no_wait, clk, rst_n, phase_reg == PH_IDLE, wait_reg == '0)
    `ASSERT_IMPLY(a_read_byte_mode, clk, rst_n, pop && rd_valid, read_mode_reg)
    `ASSERT_IMPLY(a_bit_count_range, clk, rst_n, 1'b1, bit_count_reg <= 4'(BITS_PER_BYTE))
    `ASSERT_IMPLY(a_recovery_range, clk, rst_n, 1'b1, recovery_reg <= 4'(RECOVERY_STOPS))

endmodule

`default_nettype wire

FILE: rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Byte-level I2C master stepped by one stream item per tick.
// ----------------------------------------------------------------------------
// Each item on the s_axis channel is one engine tick. It carries a request
// kind in tuser (tick only, start with address, transfer byte, stop), the
// address or write byte and the sampled SDA level in tdata, and the
// last-byte mark in tlast. Every item yields exactly one result item on the
// m_axis channel with the driven SCL and SDA levels and the engine status.
// The half_period register sets the ticks per wait unit; it is written on
// the cfg channel, and the user must write it only while no item is
// outstanding: the block itself does not enforce this. An accepted item
// passes through the queue into the result register. The engine sustains
// one item per cycle while results are taken: the front end decodes into a
// two-entry queue and the engine pops one item per cycle into a result
// register whenever it is free or being taken, so the input keeps flowing
// while a result waits, until the queue fills and s_axis_tready drops. On
// reset the engine is idle with both lines released and half_period at 1.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [7:0] req_data, [8] sda_in
    input  wire logic [15:0]         s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]          s_axis_tuser,
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] ready_res, [3] ack_fail,
    // [11:4] read_data, [12] cmd_rejected
    output logic [15:0]              m_axis_tdata,
    // [0] read_valid
    output logic                     m_axis_tuser,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [HP_WIDTH-1:0] cfg_data
);

    logic [HP_WIDTH-1:0] half_period_reg;
    logic                push;
    item_t               push_item;
    logic                pop;
    logic                queue_full;
    logic                not_empty;
    item_t               head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HP_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            half_period_reg <= cfg_data;
        end
    end

    i2cm_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    i2cm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (not_empty),
        .head      (head)
    );

    i2cm_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .half_period   (half_period_reg),
        .not_empty     (not_empty),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
